@@ rtl/core/owbm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int REG_W    = 10;
   localparam int NUM_REGS = 8;
   localparam int IDX_W    = 3;
   localparam int ADDR_W   = IDX_W + 2;
   localparam int DATA_W   = 32;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_RESET = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_READY = 2'd0,
      STATUS_BUSY  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [IDX_W-1:0] {
      REG_RESET_LOW        = 3'd0,
      REG_PRESENCE_WAIT    = 3'd1,
      REG_PRESENCE_RELEASE = 3'd2,
      REG_RECOVERY         = 3'd3,
      REG_START_LOW        = 3'd4,
      REG_WRITE_SLOT       = 3'd5,
      REG_SAMPLE_DELAY     = 3'd6,
      REG_AFTER_SAMPLE     = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      PH_READY    = 4'd0,
      PH_ERROR    = 4'd1,
      PH_RST_LOW  = 4'd2,
      PH_RST_WAIT = 4'd3,
      PH_RST_REL  = 4'd4,
      PH_WR_REC   = 4'd5,
      PH_WR_START = 4'd6,
      PH_WR_BIT   = 4'd7,
      PH_RD_REC   = 4'd8,
      PH_RD_START = 4'd9,
      PH_RD_WAIT  = 4'd10,
      PH_RD_AFTER = 4'd11
   } phase_type;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_type;

   localparam cfg_regs_type CFG_RESET = {
      10'd50, 10'd10, 10'd55, 10'd5, 10'd2, 10'd310, 10'd70, 10'd500
   };

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] write_byte;
      logic       line_level;
   } req_word_type;

   typedef struct packed {
      logic       drive_low;
      logic [1:0] bus_status;
      logic [7:0] read_byte;
   } rsp_word_type;

endpackage : owbm_pkg
`default_nettype wire

@@ rtl/core/owbm_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_req_if
// Command channel: tick, reset, write or read word with the sampled line.
// ----------------------------------------------------------------------------
interface owbm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] write_byte;
   logic       line_level;

   modport source (output valid, output func, output write_byte, output line_level,
                   input ready);
   modport sink   (input valid, input func, input write_byte, input line_level,
                   output ready);
endinterface : owbm_req_if
`default_nettype wire

@@ rtl/core/owbm_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_rsp_if
// Result channel: line drive, bus status and data shift register.
// ----------------------------------------------------------------------------
interface owbm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic [1:0] bus_status;
   logic [7:0] read_byte;

   modport source (output valid, output drive_low, output bus_status, output read_byte,
                   input ready);
   modport sink   (input valid, input drive_low, input bus_status, input read_byte,
                   output ready);
endinterface : owbm_rsp_if
`default_nettype wire

@@ rtl/core/one_wire_bus_master.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Master for a single-wire open-drain bus: reset with presence detect,
// byte write and byte read, timed by microsecond tick words.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-----------------------------------
//  req      | in        | valid/ready        | func, write_byte, line_level
//  rsp      | out       | valid/ready        | drive_low, bus_status, read_byte
//  apb      | in        | psel/penable/pready| 8 timing registers at 4*i, 10 bits
//
//  One word a cycle while rsp is not stalled: a request word is first captured in
//  the input register, then one step of the phase sequencer writes the state
//  registers, which also serve as the result register, and registers rsp.valid.
//  Reset is synchronous and active high; it returns the timing
//  registers to their defaults and the bus to ready with the line released.
//  A stalled rsp holds the sequencer and, once the input register is full,
//  drops req.ready.
// ----------------------------------------------------------------------------
module one_wire_bus_master
   import owbm_pkg::*;
#(
   parameter int TIME_WIDTH = 10
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   owbm_req_if.sink               req,
   owbm_rsp_if.source             rsp,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output      logic [DATA_W-1:0] prdata,
   output      logic              pready
);

   cfg_regs_type  cfg;
   req_word_type  in_word_ff;
   logic          in_valid_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          step;
   rsp_word_type  result;

   owbm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // advance the sequencer when a word waits and the result slot is free or leaving
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   // payload: capture on accept, no reset needed
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_word_ff.func       <= req.func;
         in_word_ff.write_byte <= req.write_byte;
         in_word_ff.line_level <= req.line_level;
      end
   end

   owbm_engine #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .word   (in_word_ff),
      .cfg    (cfg),
      .result (result)
   );

   // hold the result until taken, set it again on every step
   always_comb begin
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.drive_low  = result.drive_low;
   assign rsp.bus_status = result.bus_status;
   assign rsp.read_byte  = result.read_byte;

   // a full input register with a free result slot must move on
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |-> step)
      else $error("word stuck with the result slot free");

   // every step produces a result on the next cycle
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && step) |=> rsp_valid_ff)
      else $error("step gave no result");

   // an unaccepted result keeps its fields
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid_ff && !rsp.ready) |=> $stable(result))
      else $error("result changed while stalled");

endmodule : one_wire_bus_master
`default_nettype wire

@@ rtl/core/owbm_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_csr
// APB-style register file holding the eight slot timing registers.
// ----------------------------------------------------------------------------
module owbm_csr
   import owbm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output      logic [DATA_W-1:0] prdata,
   output      logic              pready,
   output      cfg_regs_type      cfg
);

   cfg_regs_type       regs_ff;
   logic [IDX_W-1:0]   idx;
   logic               wr_en;

   assign idx    = paddr[ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = DATA_W'(regs_ff[idx]);
   assign cfg    = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= CFG_RESET;
      end else if (wr_en) begin
         regs_ff[idx] <= pwdata[REG_W-1:0];
      end
   end

endmodule : owbm_csr
`default_nettype wire

@@ rtl/core/owbm_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_engine
// Phase sequencer: reset/presence, write slots and read slots, one word a step.
// ----------------------------------------------------------------------------
module owbm_engine
   import owbm_pkg::*;
#(
   parameter int TIME_WIDTH = 10
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_word_type word,
   input  wire cfg_regs_type cfg,
   output      rsp_word_type result
);

   localparam int LoadW = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;
   localparam logic [LoadW-1:0] TimeMax = LoadW'((64'd1 << TIME_WIDTH) - 64'd1);

   phase_type              phase_ff, phase_in;
   logic [7:0]             shift_ff, shift_in;
   logic [3:0]             idx_ff, idx_in;
   logic [TIME_WIDTH-1:0]  time_ff, time_in;
   logic                   drive_ff, drive_in;
   logic [TIME_WIDTH-1:0]  load [NUM_REGS];
   logic [3:0]             idx_next;
   logic                   moved;
   func_type               func;

   assign func     = func_type'(word.func);
   assign idx_next = idx_ff + 4'd1;

   // saturate each duration to what the timer holds
   always_comb begin
      logic [LoadW-1:0] d_ext;
      for (int i = 0; i < NUM_REGS; i++) begin
         d_ext   = LoadW'(cfg[i]);
         load[i] = (d_ext > TimeMax) ? TimeMax[TIME_WIDTH-1:0] : d_ext[TIME_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_READY;
         shift_ff <= '0;
         idx_ff   <= '0;
         time_ff  <= '0;
         drive_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         idx_ff   <= idx_in;
         time_ff  <= time_in;
         drive_ff <= drive_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      idx_in   = idx_ff;
      time_in  = time_ff;
      drive_in = drive_ff;
      moved    = 1'b0;

      // line check on every word
      if (phase_ff == PH_RST_WAIT && !word.line_level) begin
         phase_in = PH_RST_REL;
         drive_in = 1'b0;
         time_in  = load[REG_PRESENCE_RELEASE];
         moved    = 1'b1;
      end else if (phase_ff == PH_RST_REL && word.line_level) begin
         phase_in = PH_READY;
         drive_in = 1'b0;
         time_in  = '0;
         moved    = 1'b1;
      end

      unique case (func)
         FUNC_RESET: begin
            if (phase_in == PH_READY || phase_in == PH_ERROR) begin
               phase_in = PH_RST_LOW;
               drive_in = 1'b1;
               time_in  = load[REG_RESET_LOW];
            end
         end
         FUNC_WRITE: begin
            if (phase_in == PH_READY) begin
               shift_in = word.write_byte;
               idx_in   = '0;
               phase_in = PH_WR_REC;
               drive_in = 1'b0;
               time_in  = load[REG_RECOVERY];
            end
         end
         FUNC_READ: begin
            if (phase_in == PH_READY) begin
               shift_in = '0;
               idx_in   = '0;
               phase_in = PH_RD_REC;
               drive_in = 1'b0;
               time_in  = load[REG_RECOVERY];
            end
         end
         FUNC_TICK: begin
            if (!moved && phase_ff >= PH_RST_LOW && phase_ff <= PH_RD_AFTER) begin
               if (time_ff > TIME_WIDTH'(1)) begin
                  time_in = time_ff - TIME_WIDTH'(1);
               end else begin
                  unique case (phase_ff)
                     PH_RST_LOW: begin
                        phase_in = PH_RST_WAIT;
                        drive_in = 1'b0;
                        time_in  = load[REG_PRESENCE_WAIT];
                     end
                     PH_RST_WAIT, PH_RST_REL: begin
                        phase_in = PH_ERROR;
                        drive_in = 1'b0;
                        time_in  = '0;
                     end
                     PH_WR_REC: begin
                        phase_in = PH_WR_START;
                        drive_in = 1'b1;
                        time_in  = load[REG_START_LOW];
                     end
                     PH_WR_START: begin
                        phase_in = PH_WR_BIT;
                        drive_in = ~shift_ff[idx_ff[2:0]];
                        time_in  = load[REG_WRITE_SLOT];
                     end
                     PH_WR_BIT: begin
                        idx_in   = idx_next;
                        drive_in = 1'b0;
                        if (!idx_next[3]) begin
                           phase_in = PH_WR_REC;
                           time_in  = load[REG_RECOVERY];
                        end else begin
                           phase_in = PH_READY;
                           time_in  = '0;
                        end
                     end
                     PH_RD_REC: begin
                        phase_in = PH_RD_START;
                        drive_in = 1'b1;
                        time_in  = load[REG_START_LOW];
                     end
                     PH_RD_START: begin
                        phase_in = PH_RD_WAIT;
                        drive_in = 1'b0;
                        time_in  = load[REG_SAMPLE_DELAY];
                     end
                     PH_RD_WAIT: begin
                        if (word.line_level) begin
                           shift_in[idx_ff[2:0]] = 1'b1;
                        end
                        idx_in   = idx_next;
                        phase_in = PH_RD_AFTER;
                        drive_in = 1'b0;
                        time_in  = load[REG_AFTER_SAMPLE];
                     end
                     PH_RD_AFTER: begin
                        drive_in = 1'b0;
                        if (!idx_ff[3]) begin
                           phase_in = PH_RD_REC;
                           time_in  = load[REG_RECOVERY];
                        end else begin
                           phase_in = PH_READY;
                           time_in  = '0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.drive_low = drive_ff;
      result.read_byte = shift_ff;
      if (phase_ff == PH_READY) begin
         result.bus_status = STATUS_READY;
      end else if (phase_ff == PH_ERROR) begin
         result.bus_status = STATUS_ERROR;
      end else begin
         result.bus_status = STATUS_BUSY;
      end
   end

   // the line is pulled low only in the low parts of a slot or the reset pulse
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      drive_ff |-> (phase_ff == PH_RST_LOW || phase_ff == PH_WR_START ||
                    phase_ff == PH_WR_BIT || phase_ff == PH_RD_START))
      else $error("line driven low outside a low phase");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= 4'd8)
      else $error("bit index beyond one byte");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_READY || phase_ff == PH_ERROR) |-> time_ff == '0)
      else $error("timer left running while idle");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && !step) |=> ($stable(phase_ff) && $stable(shift_ff) && $stable(time_ff)))
      else $error("state moved without a step");

endmodule : owbm_engine
`default_nettype wire
